// File: rtl/u8up_pkg.sv
// Shared types, constants and the case-fold function for the UTF-8 upper-casing transcoder.
`default_nettype none

package u8up_pkg;

    // Code point width and range limits.
    localparam int CP_W = 21;
    localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MAX  = 21'h10FFFF;

    // Smallest legal code point for each sequence length.
    localparam logic [CP_W-1:0] MIN_CP_2 = 21'h000080;
    localparam logic [CP_W-1:0] MIN_CP_3 = 21'h000800;
    localparam logic [CP_W-1:0] MIN_CP_4 = 21'h010000;

    // Default queue depths.
    localparam int MID_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 4;

    // One decoded step as it travels from the front end to the back end.
    typedef struct packed {
        logic            is_cp;    // 1: fold and encode cp, 0: emit raw bytes
        logic [CP_W-1:0] cp;
        logic [3:0][7:0] raw;
        logic [2:0]      count;    // number of raw bytes, 1 to 4
        logic            str_end;
    } mid_entry_t;

    // One output beat.
    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       string_last;
    } out_beat_t;

    // Simple upper-case fold over ASCII, Latin-1, Latin Extended-A, Greek and Cyrillic.
    function automatic logic [CP_W-1:0] fold_upper(input logic [CP_W-1:0] cp);
        logic [CP_W-1:0] r;
        logic [CP_W-1:0] dn;
        logic            odd;
        dn  = cp - 21'd1;
        odd = cp[0];
        r   = cp;
        priority if (cp >= 21'h61 && cp <= 21'h7A) r = cp - 21'h20;
        else if (cp < 21'h80) r = cp;
        else if (cp >= 21'hE0 && cp <= 21'hFE && cp != 21'hF7) r = cp - 21'h20;
        else if (cp == 21'hFF) r = 21'h178;
        else if (cp == 21'h131) r = 21'h49;
        else if (cp == 21'h17F) r = 21'h53;
        else if (cp >= 21'h100 && cp <= 21'h137) r = odd ? dn : cp;
        else if (cp >= 21'h139 && cp <= 21'h148) r = odd ? cp : dn;
        else if (cp >= 21'h14A && cp <= 21'h177) r = odd ? dn : cp;
        else if (cp >= 21'h179 && cp <= 21'h17E) r = odd ? cp : dn;
        else if (cp == 21'h3AC) r = 21'h386;
        else if (cp >= 21'h3AD && cp <= 21'h3AF) r = cp - 21'h25;
        else if (cp == 21'h3C2) r = 21'h3A3;
        else if (cp >= 21'h3B1 && cp <= 21'h3CB) r = cp - 21'h20;
        else if (cp == 21'h3CC) r = 21'h38C;
        else if (cp >= 21'h3CD && cp <= 21'h3CE) r = cp - 21'h3F;
        else if (cp >= 21'h430 && cp <= 21'h44F) r = cp - 21'h20;
        else if (cp >= 21'h450 && cp <= 21'h45F) r = cp - 21'h50;
        else if (cp >= 21'h460 && cp <= 21'h481) r = odd ? dn : cp;
        else if (cp >= 21'h48A && cp <= 21'h4BF) r = odd ? dn : cp;
        else if (cp >= 21'h4C1 && cp <= 21'h4CE) r = odd ? cp : dn;
        else if (cp >= 21'h4D0 && cp <= 21'h52F) r = odd ? dn : cp;
        else r = cp;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/utf8_uppercase_transcoder_top.sv
// UTF-8 upper-casing transcoder: a byte stream in, the upper-cased byte stream out.
// Input channel: a beat (in_byte, string_end) is taken at a clock edge with push high and
// full low. Output channel: while empty is low the oldest beat (out_byte, run_last,
// string_last) is shown, and it is taken at an edge with pop high.
// Each input beat gives zero to four output beats; run_last marks the last beat of one
// input beat, and string_last the last beat of a string.
// The first output beat of an input beat passes the middle queue, the serializer registers
// and the output queue before it shows. Throughput: one input beat per cycle while full is
// low; the back-end serializer sends one output beat per cycle while the output queue has
// room, so an n-byte expansion holds it until all n leave; the middle queue absorbs that.
// Bytes of an unfinished multi-byte sequence stay in the front end and give no beat until
// the sequence completes, breaks or the string ends.
// Reset clears the held sequence and empties both queues; full is low afterwards.
// When the receiver stops popping, the output queue fills, the serializer holds, the
// middle queue fills and full rises; nothing is lost.
`default_nettype none

module utf8_uppercase_transcoder_top
    import u8up_pkg::*;
#(
    parameter int MID_DEPTH = MID_DEPTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] in_byte,
    input  wire logic       string_end,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      out_byte,
    output logic            run_last,
    output logic            string_last
);

    logic       mid_push;
    logic       mid_full;
    logic       mid_pop;
    logic       mid_empty;
    mid_entry_t mid_wdata;
    mid_entry_t mid_rdata;
    logic       obuf_push;
    logic       obuf_full;
    out_beat_t  obuf_wdata;
    out_beat_t  obuf_rdata;

    assign full = mid_full;

    // Decode and classify.
    u8up_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_push    (push),
        .in_byte    (in_byte),
        .string_end (string_end),
        .mid_full   (mid_full),
        .mid_push   (mid_push),
        .mid_data   (mid_wdata)
    );

    // Queue between the front and back ends.
    u8up_fifo #(
        .WIDTH ($bits(mid_entry_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_push  (mid_push),
        .wr_data  (mid_wdata),
        .wr_full  (mid_full),
        .rd_pop   (mid_pop),
        .rd_data  (mid_rdata),
        .rd_empty (mid_empty)
    );

    // Fold, encode and serialize.
    u8up_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_data  (mid_rdata),
        .mid_pop   (mid_pop),
        .out_full  (obuf_full),
        .out_push  (obuf_push),
        .out_data  (obuf_wdata)
    );

    // Output queue.
    u8up_fifo #(
        .WIDTH ($bits(out_beat_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_push  (obuf_push),
        .wr_data  (obuf_wdata),
        .wr_full  (obuf_full),
        .rd_pop   (pop),
        .rd_data  (obuf_rdata),
        .rd_empty (empty)
    );

    assign out_byte    = obuf_rdata.data;
    assign run_last    = obuf_rdata.run_last;
    assign string_last = obuf_rdata.string_last;

endmodule

`default_nettype wire

// File: rtl/u8up_fifo.sv
// Small first-in first-out queue built from registers.
`default_nettype none

module u8up_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_push,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  wr_full,
    input  wire logic             rd_pop,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  rd_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             wr_en;
    logic             rd_en;

    // Handshake qualification and status.
    assign wr_full  = (count_reg == CNT_W'(DEPTH));
    assign rd_empty = (count_reg == '0);
    assign wr_en    = wr_push && !wr_full;
    assign rd_en    = rd_pop && !rd_empty;
    assign rd_data  = mem[rd_ptr_reg];

    // Pointer and occupancy update with wrap at the last entry.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(wr_en) - CNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage is written only; it needs no reset.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/u8up_front.sv
// Front end: accepts input bytes, tracks partial sequences and classifies each step.
`default_nettype none

module u8up_front
    import u8up_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_push,
    input  wire logic [7:0] in_byte,
    input  wire logic       string_end,
    input  wire logic       mid_full,
    output logic            mid_push,
    output mid_entry_t      mid_data
);

    logic [7:0]      pend_reg [3];
    logic [1:0]      pcount_reg, pcount_next;
    logic [1:0]      expect_reg, expect_next;
    logic [CP_W-1:0] cp_reg, cp_next;

    logic            accept;
    logic            active;
    logic            is_cont;
    logic            lead2, lead3, lead4, lead;
    logic            is_ascii;
    logic [1:0]      eff_cnt;
    logic [1:0]      exp_dec;
    logic [CP_W-1:0] cp_shift;
    logic            bad_cp;
    logic            too_short;
    logic [7:0]      slot_byte;
    logic            slot_used;
    logic            store_en;
    logic [1:0]      store_idx;
    logic            has_out;
    mid_entry_t      entry;

    assign accept = in_push && !mid_full;

    // Byte classification.
    always_comb
    begin
        active   = (pcount_reg != 2'd0) && (expect_reg != 2'd0);
        is_cont  = (in_byte[7:6] == 2'b10);
        lead2    = (in_byte[7:5] == 3'b110);
        lead3    = (in_byte[7:4] == 4'b1110);
        lead4    = (in_byte[7:3] == 5'b11110);
        lead     = lead2 || lead3 || lead4;
        is_ascii = !in_byte[7];
        cp_shift = {cp_reg[CP_W-7:0], in_byte[5:0]};
        exp_dec  = expect_reg - 2'd1;
        unique case (pcount_reg)
            2'd1:    too_short = (cp_shift < MIN_CP_2);
            2'd2:    too_short = (cp_shift < MIN_CP_3);
            default: too_short = (cp_shift < MIN_CP_4);
        endcase
        bad_cp = too_short || ((cp_shift >= SURR_LO) && (cp_shift <= SURR_HI))
                 || (cp_shift > CP_MAX);
    end

    // Step decision: what leaves the front end and what stays held.
    always_comb
    begin
        pcount_next = pcount_reg;
        expect_next = expect_reg;
        cp_next     = cp_reg;
        store_en    = 1'b0;
        store_idx   = 2'd0;
        has_out     = 1'b0;
        eff_cnt     = active ? pcount_reg : 2'd0;
        slot_byte   = in_byte;
        slot_used   = 1'b1;
        entry       = '0;
        entry.is_cp = 1'b0;

        if (active && is_cont)
        begin
            // Continuation of the held sequence.
            if (exp_dec != 2'd0)
            begin
                if (string_end)
                begin
                    has_out     = 1'b1;
                    pcount_next = 2'd0;
                    expect_next = 2'd0;
                    cp_next     = '0;
                end
                else
                begin
                    slot_used   = 1'b0;
                    store_en    = 1'b1;
                    store_idx   = pcount_reg;
                    pcount_next = pcount_reg + 2'd1;
                    expect_next = exp_dec;
                    cp_next     = cp_shift;
                end
            end
            else
            begin
                has_out     = 1'b1;
                entry.is_cp = !bad_cp;
                pcount_next = 2'd0;
                expect_next = 2'd0;
                cp_next     = '0;
            end
        end
        else
        begin
            // No hold or break: held bytes go raw, then the new byte unless it opens a hold.
            if (is_ascii && in_byte >= 8'h61 && in_byte <= 8'h7A)
            begin
                slot_byte = in_byte - 8'h20;
            end
            slot_used   = !(lead && !string_end);
            has_out     = (eff_cnt != 2'd0) || slot_used;
            pcount_next = 2'd0;
            expect_next = 2'd0;
            cp_next     = '0;
            if (lead && !string_end)
            begin
                store_en    = 1'b1;
                store_idx   = 2'd0;
                pcount_next = 2'd1;
                priority if (lead2)
                begin
                    expect_next = 2'd1;
                    cp_next     = CP_W'(in_byte[4:0]);
                end
                else if (lead3)
                begin
                    expect_next = 2'd2;
                    cp_next     = CP_W'(in_byte[3:0]);
                end
                else
                begin
                    expect_next = 2'd3;
                    cp_next     = CP_W'(in_byte[2:0]);
                end
            end
        end

        entry.cp      = cp_shift;
        entry.raw[0]  = (eff_cnt > 2'd0) ? pend_reg[0] : slot_byte;
        entry.raw[1]  = (eff_cnt > 2'd1) ? pend_reg[1] : slot_byte;
        entry.raw[2]  = (eff_cnt > 2'd2) ? pend_reg[2] : slot_byte;
        entry.raw[3]  = slot_byte;
        entry.count   = {1'b0, eff_cnt} + {2'b00, slot_used};
        entry.str_end = string_end;
    end

    assign mid_push = accept && has_out;
    assign mid_data = entry;

    // Sequence state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg <= 2'd0;
            expect_reg <= 2'd0;
            cp_reg     <= '0;
        end
        else if (accept)
        begin
            pcount_reg <= pcount_next;
            expect_reg <= expect_next;
            cp_reg     <= cp_next;
        end
    end

    // Held bytes of a partial sequence.
    always_ff @(posedge clk)
    begin
        if (accept && store_en)
        begin
            pend_reg[store_idx] <= in_byte;
        end
    end

endmodule

`default_nettype wire

// File: rtl/u8up_back.sv
// Back end: folds and re-encodes decoded code points and sends bytes out one beat at a time.
`default_nettype none

module u8up_back
    import u8up_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       mid_empty,
    input  wire mid_entry_t mid_data,
    output logic            mid_pop,
    input  wire logic       out_full,
    output logic            out_push,
    output out_beat_t       out_data
);

    logic            ser_valid_reg, ser_valid_next;
    logic [3:0][7:0] ser_bytes_reg, ser_bytes_next;
    logic [2:0]      ser_count_reg, ser_count_next;
    logic [1:0]      ser_idx_reg, ser_idx_next;
    logic            ser_end_reg, ser_end_next;

    logic [CP_W-1:0] folded;
    logic [3:0][7:0] dec_bytes;
    logic [2:0]      dec_count;
    logic            ser_last;
    logic            load;

    // Fold and encode the entry at the head of the queue; raw entries pass unchanged.
    always_comb
    begin
        folded    = fold_upper(mid_data.cp);
        dec_bytes = mid_data.raw;
        dec_count = mid_data.count;
        if (mid_data.is_cp)
        begin
            dec_bytes = '0;
            priority if (folded < MIN_CP_2)
            begin
                dec_bytes[0] = folded[7:0];
                dec_count    = 3'd1;
            end
            else if (folded < MIN_CP_3)
            begin
                dec_bytes[0] = {3'b110, folded[10:6]};
                dec_bytes[1] = {2'b10, folded[5:0]};
                dec_count    = 3'd2;
            end
            else if (folded < MIN_CP_4)
            begin
                dec_bytes[0] = {4'b1110, folded[15:12]};
                dec_bytes[1] = {2'b10, folded[11:6]};
                dec_bytes[2] = {2'b10, folded[5:0]};
                dec_count    = 3'd3;
            end
            else
            begin
                dec_bytes[0] = {5'b11110, folded[20:18]};
                dec_bytes[1] = {2'b10, folded[17:12]};
                dec_bytes[2] = {2'b10, folded[11:6]};
                dec_bytes[3] = {2'b10, folded[5:0]};
                dec_count    = 3'd4;
            end
        end
    end

    // Serializer: one beat per cycle unless out_full, next entry loaded as last beat leaves.
    always_comb
    begin
        ser_last             = (ser_idx_reg == 2'(ser_count_reg - 3'd1));
        out_push             = ser_valid_reg && !out_full;
        out_data.data        = ser_bytes_reg[ser_idx_reg];
        out_data.run_last    = ser_last;
        out_data.string_last = ser_last && ser_end_reg;
        load                 = !ser_valid_reg || (out_push && ser_last);
        mid_pop              = load && !mid_empty;

        ser_valid_next = ser_valid_reg;
        ser_bytes_next = ser_bytes_reg;
        ser_count_next = ser_count_reg;
        ser_idx_next   = ser_idx_reg;
        ser_end_next   = ser_end_reg;
        if (load)
        begin
            ser_valid_next = !mid_empty;
            ser_bytes_next = dec_bytes;
            ser_count_next = dec_count;
            ser_idx_next   = 2'd0;
            ser_end_next   = mid_data.str_end;
        end
        else if (out_push)
        begin
            ser_idx_next = ser_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            ser_idx_reg   <= 2'd0;
        end
        else
        begin
            ser_valid_reg <= ser_valid_next;
            ser_idx_reg   <= ser_idx_next;
        end
    end

    // Beat payload needs no reset.
    always_ff @(posedge clk)
    begin
        ser_bytes_reg <= ser_bytes_next;
        ser_count_reg <= ser_count_next;
        ser_end_reg   <= ser_end_next;
    end

endmodule

`default_nettype wire
